// ----- rtl/key_short_long_press_events_assert.svh -----
// Assertion macros shared by the key event detector RTL.
// Both expect clk and rst to be visible where they are used.
`ifndef KEY_SHORT_LONG_PRESS_EVENTS_ASSERT_SVH
`define KEY_SHORT_LONG_PRESS_EVENTS_ASSERT_SVH

// Same-cycle implication
`define KSLPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KSLPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kslpe_pkg.sv -----
package kslpe_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 8;
  localparam int KEY_W     = 2;
  localparam int MASK_W    = 4;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 8;
  localparam int THRP_W    = 15;

  // Key count: default and the most keys that have an enable bit
  localparam int KEYS_DEF  = 4;
  localparam int EV_KEYS   = 4;

  // Timing constants (ms)
  localparam logic [TIME_W-1:0] DEBOUNCE_MS  = 32'd50;
  localparam logic [TIME_W-1:0] REPEAT_MS    = 32'd300;
  localparam logic [6:0]        LONG_UNIT_MS = 7'd100;

  // Register reset values
  localparam logic [MASK_W-1:0] ENABLE_RST = 4'hF;
  localparam logic [MASK_W-1:0] INVERT_RST = 4'hF;
  localparam logic [CFG_W-1:0]  LPT_RST    = 32'h0A0A_0A0A;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ENABLE = 2'd0,
    REG_INVERT     = 2'd1,
    REG_LONG_TIMES = 2'd2
  } kslpe_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CALC,
    ST_EMIT
  } kslpe_state_t;

  // One key's stored state, one memory word
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] long_sent;
    logic [TIME_W-1:0] press_start;
  } kslpe_entry_t;

  localparam int ENTRY_W = $bits(kslpe_entry_t);

  // Zero is the idle marker, so a time of zero is stored as one
  function automatic logic [TIME_W-1:0] nonzero_time(input logic [TIME_W-1:0] t);
    nonzero_time = (t == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : t;
  endfunction

endpackage

// ----- rtl/kslpe_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle
module kslpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/key_short_long_press_events.sv -----
// Key short/long press event detector. Each item brings the millisecond time and
// the pin levels of all keys; keys are visited in index order through one state
// memory (press start, last long time, press counter per key) with one read port,
// one key per cycle. After the key walk the item's events (0 to 4) are handed out
// in key order, waiting while the output stalls; the next item is taken once all
// of this item's events are in the output register. Short events need 50 ms of
// press, long events fire at the key's threshold times 100 ms and repeat every
// 300 ms while held. last_event marks the item's final event.
`include "key_short_long_press_events_assert.svh"

module key_short_long_press_events #(
  parameter int KEYS = kslpe_pkg::KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [kslpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kslpe_pkg::CFG_W-1:0]    cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kslpe_pkg::TIME_W-1:0]   now_ms,
  input  logic [kslpe_pkg::MASK_W-1:0]   pin_levels,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kslpe_pkg::KEY_W-1:0]    key_index,
  output logic [kslpe_pkg::CNT_W-1:0]    press_count,
  output logic                           is_long,
  output logic                           last_event
);

  // Only keys with an enable bit are ever processed
  localparam int NPROC = (KEYS < kslpe_pkg::EV_KEYS) ? KEYS : kslpe_pkg::EV_KEYS;
  localparam int AW    = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int EV_N  = kslpe_pkg::EV_KEYS;

  kslpe_pkg::kslpe_state_t state, state_next;

  logic [kslpe_pkg::MASK_W-1:0] enable_q;
  logic [kslpe_pkg::MASK_W-1:0] invert_q;
  logic [kslpe_pkg::CFG_W-1:0]  lpt_q;

  logic [kslpe_pkg::TIME_W-1:0] now_q;
  logic [kslpe_pkg::MASK_W-1:0] pins_q;
  logic [kslpe_pkg::KEY_W-1:0]  key;
  logic                         last_key;

  // memory side
  logic [NPROC-1:0]             valid;
  logic                         rd_ok;
  logic [kslpe_pkg::KEY_W-1:0]  raddr_ext;
  logic                         ram_we;
  logic [kslpe_pkg::ENTRY_W-1:0] ram_rdata;
  kslpe_pkg::kslpe_entry_t      cur, upd;

  // per-key event buffer
  logic [EV_N-1:0]              ev_pend;
  logic                         ev_long [EV_N];
  logic [kslpe_pkg::CNT_W-1:0]  ev_cnt  [EV_N];

  // key update
  logic                         key_en, pressed, hit, hit_long;
  logic [kslpe_pkg::TIME_W-1:0] d_start, d_long, now_nz;
  logic [kslpe_pkg::THR_W-1:0]  thr_byte;
  logic [kslpe_pkg::THRP_W-1:0] thr;

  // emit selection
  logic                         emit_load, emit_last;
  logic [kslpe_pkg::KEY_W-1:0]  emit_key;
  logic [EV_N-1:0]              emit_onehot;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_q <= kslpe_pkg::ENABLE_RST;
      invert_q <= kslpe_pkg::INVERT_RST;
      lpt_q    <= kslpe_pkg::LPT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        kslpe_pkg::REG_KEY_ENABLE: enable_q <= cfg_data[kslpe_pkg::MASK_W-1:0];
        kslpe_pkg::REG_INVERT:     invert_q <= cfg_data[kslpe_pkg::MASK_W-1:0];
        kslpe_pkg::REG_LONG_TIMES: lpt_q    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign last_key = (key == kslpe_pkg::KEY_W'(NPROC - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kslpe_pkg::ST_IDLE: if (in_valid) state_next = kslpe_pkg::ST_RD;
      kslpe_pkg::ST_RD:   state_next = kslpe_pkg::ST_CALC;
      kslpe_pkg::ST_CALC: if (last_key) state_next = kslpe_pkg::ST_EMIT;
      kslpe_pkg::ST_EMIT: begin
        if (ev_pend == '0 || (emit_load && emit_last)) state_next = kslpe_pkg::ST_IDLE;
      end
      default: state_next = kslpe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready  = (state == kslpe_pkg::ST_IDLE);
    ram_we    = (state == kslpe_pkg::ST_CALC) && key_en;
    raddr_ext = (state == kslpe_pkg::ST_CALC) ? key + 2'd1 : key;
    emit_load = (state == kslpe_pkg::ST_EMIT) && (ev_pend != '0) &&
                (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kslpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture and key walk
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (in_valid && in_ready) begin
      key <= '0;
    end else if (state == kslpe_pkg::ST_CALC && !last_key) begin
      key <= key + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_q  <= now_ms;
      pins_q <= pin_levels;
    end
  end

  // State memory; a never-written entry reads as all zero
  kslpe_ram #(
    .WIDTH (kslpe_pkg::ENTRY_W),
    .DEPTH (NPROC)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(key)),
    .wdata (upd),
    .raddr (AW'(raddr_ext)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= ({1'b0, raddr_ext} < 3'(NPROC)) && valid[AW'(raddr_ext)];
      if (ram_we) valid[AW'(key)] <= 1'b1;
    end
  end

  assign cur = rd_ok ? kslpe_pkg::kslpe_entry_t'(ram_rdata) : '0;

  // Per-key press logic
  always_comb begin
    key_en   = enable_q[key];
    pressed  = pins_q[key] ^ invert_q[key];
    now_nz   = kslpe_pkg::nonzero_time(now_q);
    d_start  = now_q - cur.press_start;
    d_long   = now_q - cur.long_sent;
    thr_byte = kslpe_pkg::THR_W'(lpt_q >> {key, 3'b000});
    thr      = kslpe_pkg::THRP_W'(thr_byte) * kslpe_pkg::THRP_W'(kslpe_pkg::LONG_UNIT_MS);
    upd      = cur;
    hit      = 1'b0;
    hit_long = 1'b0;
    if (!pressed) begin
      if (cur.press_start != '0) begin
        if (d_start >= kslpe_pkg::DEBOUNCE_MS && cur.long_sent == '0) begin
          upd.cnt = cur.cnt + 8'd1;
          hit     = 1'b1;
        end
        upd.press_start = '0;
      end
    end else if (cur.press_start != '0) begin
      if (cur.long_sent != '0) begin
        if (d_long >= kslpe_pkg::REPEAT_MS) begin
          upd.long_sent = now_nz;
          hit           = 1'b1;
          hit_long      = 1'b1;
        end
      end else if (d_start >= kslpe_pkg::TIME_W'(thr)) begin
        upd.cnt       = cur.cnt + 8'd1;
        upd.long_sent = now_nz;
        hit           = 1'b1;
        hit_long      = 1'b1;
      end
    end else begin
      upd.press_start = now_nz;
      upd.long_sent   = '0;
    end
  end

  // Event buffer: filled during the key walk, drained in key order
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_pend <= '0;
    end else if (state == kslpe_pkg::ST_CALC && key_en && hit) begin
      ev_pend[key] <= 1'b1;
    end else if (emit_load) begin
      ev_pend <= ev_pend & ~emit_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kslpe_pkg::ST_CALC) begin
      ev_long[key] <= hit_long;
      ev_cnt[key]  <= upd.cnt;
    end
  end

  // Lowest pending key goes next
  always_comb begin
    emit_key    = '0;
    emit_onehot = '0;
    for (int i = EV_N - 1; i >= 0; i--) begin
      if (ev_pend[i]) begin
        emit_key    = kslpe_pkg::KEY_W'(i);
        emit_onehot = EV_N'(1) << i;
      end
    end
    emit_last = ((ev_pend & ~emit_onehot) == '0);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      key_index   <= emit_key;
      press_count <= ev_cnt[emit_key];
      is_long     <= ev_long[emit_key];
      last_event  <= emit_last;
    end
  end

  // Checks
  `KSLPE_ASSERT_NEXT(a_accept_starts_read, in_valid && in_ready, state == kslpe_pkg::ST_RD, "accepted item did not start a key read")
  `KSLPE_ASSERT_NOW(a_key_in_range, state == kslpe_pkg::ST_CALC, {1'b0, key} < 3'(NPROC), "key walk beyond processed keys")
  `KSLPE_ASSERT_NEXT(a_emit_drains, state == kslpe_pkg::ST_EMIT && ev_pend == '0, state == kslpe_pkg::ST_IDLE, "empty event buffer did not return to idle")
  `KSLPE_ASSERT_NOW(a_load_from_emit, $rose(out_valid), $past(state) == kslpe_pkg::ST_EMIT, "output loaded outside emit phase")

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kslpe_pkg::*;

  localparam int NKEYS           = 4;
  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 48;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LIMIT_CYCLES    = 250_000;

  // Index 3 names no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic             is_long;
    logic             last;
  } key_event_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [TIME_W-1:0]    value;   // time for an item, data for a write
    logic [MASK_W-1:0]    pins;
    row_check_t           check;
    key_event_t           ev;
  } script_row_t;

  localparam key_event_t NO_EV = '0;
  localparam int SCRIPT_ROWS = 27;

  // Directed script, reset settings: all keys on, inverted, 1000 ms long press
  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_ITEM,  '0, 32'd0,          4'hF, CHK_NONE,  NO_EV},
    // press at time zero is stored as 1, so 50 ms later is still too short
    '{ROW_ITEM,  '0, 32'd0,          4'hE, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd50,         4'hF, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd100,        4'hE, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd150,        4'hF, CHK_ONE,   '{2'd0, 8'd1, 1'b0, 1'b1}},
    // long press on key 1, repeat exactly at 300 ms, no short on release
    '{ROW_ITEM,  '0, 32'd200,        4'hD, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd1200,       4'hD, CHK_ONE,   '{2'd1, 8'd1, 1'b1, 1'b1}},
    '{ROW_ITEM,  '0, 32'd1499,       4'hD, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd1500,       4'hD, CHK_ONE,   '{2'd1, 8'd1, 1'b1, 1'b1}},
    '{ROW_ITEM,  '0, 32'd1600,       4'hF, CHK_NONE,  NO_EV},
    // all keys at once: four events per item
    '{ROW_ITEM,  '0, 32'd2000,       4'h0, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd4000,       4'h0, CHK_MODEL, NO_EV},
    '{ROW_ITEM,  '0, 32'd4300,       4'h0, CHK_MODEL, NO_EV},
    '{ROW_ITEM,  '0, 32'd4400,       4'hF, CHK_NONE,  NO_EV},
    // press across the 32-bit wrap
    '{ROW_ITEM,  '0, 32'hFFFF_FFE0,  4'h7, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'h0000_0020,  4'hF, CHK_ONE,   '{2'd3, 8'd2, 1'b0, 1'b1}},
    '{ROW_ITEM,  '0, 32'd0,          4'hB, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd1001,       4'hB, CHK_ONE,   '{2'd2, 8'd2, 1'b1, 1'b1}},
    // zero threshold, dropped write to the spare index, plain polarity
    '{ROW_WRITE, REG_LONG_TIMES, 32'h0000_0000, 4'h0, CHK_NONE, NO_EV},
    '{ROW_WRITE, REG_UNUSED,     32'hFFFF_FFFF, 4'h0, CHK_NONE, NO_EV},
    '{ROW_WRITE, REG_INVERT,     32'h0000_0000, 4'h0, CHK_NONE, NO_EV},
    '{ROW_ITEM,  '0, 32'd5000,       4'h1, CHK_NONE,  NO_EV},
    '{ROW_ITEM,  '0, 32'd5000,       4'h1, CHK_ONE,   '{2'd0, 8'd3, 1'b1, 1'b1}},
    // disabled keys keep their state
    '{ROW_WRITE, REG_KEY_ENABLE, 32'h0000_0000, 4'h0, CHK_NONE, NO_EV},
    '{ROW_ITEM,  '0, 32'd6000,       4'h0, CHK_NONE,  NO_EV},
    '{ROW_WRITE, REG_KEY_ENABLE, 32'h0000_000F, 4'h0, CHK_NONE, NO_EV},
    '{ROW_ITEM,  '0, 32'd6100,       4'h0, CHK_NONE,  NO_EV}
  };

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    now_ms     = '0;
  logic [MASK_W-1:0]    pin_levels = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [KEY_W-1:0]     key_index;
  logic [CNT_W-1:0]     press_count;
  logic                 is_long;
  logic                 last_event;

  // Mirror of the key state and the registers
  logic [MASK_W-1:0] model_enable     = ENABLE_RST;
  logic [MASK_W-1:0] model_invert     = INVERT_RST;
  logic [CFG_W-1:0]  model_long_times = LPT_RST;
  logic [TIME_W-1:0] held_since    [NKEYS] = '{default: '0};
  logic [TIME_W-1:0] long_fired_at [NKEYS] = '{default: '0};
  logic [CNT_W-1:0]  presses       [NKEYS] = '{default: '0};

  key_event_t due_events [$];
  int error_count = 0;

  always #HALF_PERIOD clk = ~clk;

  key_short_long_press_events dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .now_ms      (now_ms),
    .pin_levels  (pin_levels),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_index   (key_index),
    .press_count (press_count),
    .is_long     (is_long),
    .last_event  (last_event)
  );

  // Scan all keys for one item, update the mirror, collect the events in key order
  function automatic void scan_keys(input logic [TIME_W-1:0] t,
                                    input logic [MASK_W-1:0] pins,
                                    ref key_event_t found[$]);
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] limit;
    logic              pressed;
    logic              fire;
    logic              fire_long;
    key_event_t        ev;
    stamp = (t == '0) ? 32'd1 : t;
    found.delete();
    for (int k = 0; k < NKEYS; k++) begin
      if (model_enable[k]) begin
        fire = 1'b0;
        fire_long = 1'b0;
        pressed = pins[k] ^ model_invert[k];
        if (!pressed) begin
          // release: short event only after debounce and with no long sent
          if (held_since[k] != '0) begin
            if (t - held_since[k] >= DEBOUNCE_MS && long_fired_at[k] == '0) begin
              presses[k] = presses[k] + 1'b1;
              fire = 1'b1;
            end
            held_since[k] = '0;
          end
        end else if (held_since[k] == '0) begin
          held_since[k] = stamp;
          long_fired_at[k] = '0;
        end else if (long_fired_at[k] != '0) begin
          // repeat while held, counter unchanged
          if (t - long_fired_at[k] >= REPEAT_MS) begin
            long_fired_at[k] = stamp;
            fire = 1'b1;
            fire_long = 1'b1;
          end
        end else begin
          limit = TIME_W'(model_long_times[8*k +: 8]) * TIME_W'(LONG_UNIT_MS);
          if (t - held_since[k] >= limit) begin
            presses[k] = presses[k] + 1'b1;
            long_fired_at[k] = stamp;
            fire = 1'b1;
            fire_long = 1'b1;
          end
        end
        if (fire) begin
          ev.key = KEY_W'(k);
          ev.count = presses[k];
          ev.is_long = fire_long;
          ev.last = 1'b0;
          found.push_back(ev);
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Runs of items with no gap alternate with runs of random gaps
  function automatic int draw_gap(input int idx);
    return ((idx / 30) % 3 == 0) ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Register write, issued only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KEY_ENABLE: model_enable = data[MASK_W-1:0];
      REG_INVERT:     model_invert = data[MASK_W-1:0];
      REG_LONG_TIMES: model_long_times = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item, hold it until taken, then queue what it should cause
  task automatic send_item(input logic [TIME_W-1:0] t, input logic [MASK_W-1:0] pins,
                           input int gap, input row_check_t check, input key_event_t typed);
    key_event_t found[$];
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    now_ms     <= t;
    pin_levels <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_keys(t, pins, found);
    case (check)
      CHK_MODEL: foreach (found[i]) due_events.push_back(found[i]);
      CHK_ONE:   due_events.push_back(typed);
      default: ;
    endcase
  endtask

  // Item source: directed script, then random phases under changing settings
  initial begin : item_source
    logic [TIME_W-1:0] clock_ms;
    logic [MASK_W-1:0] level;
    int r;
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    n = 0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_item(script[i].value, script[i].pins, draw_gap(n), script[i].check,
                  script[i].ev);
        n++;
      end
    end

    clock_ms = 32'd10000;
    level = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_INVERT, '0);
          write_reg(REG_LONG_TIMES, 32'h0302_0105);
        end
        1: begin
          write_reg(REG_INVERT, 32'h0000_000F);
          write_reg(REG_LONG_TIMES, '1);
        end
        2: begin
          write_reg(REG_KEY_ENABLE, 32'h0000_0005);
          write_reg(REG_INVERT, 32'h0000_000A);
          write_reg(REG_LONG_TIMES, $urandom);
        end
        3: begin
          write_reg(REG_KEY_ENABLE, $urandom_range(0, 15));
          write_reg(REG_INVERT, $urandom_range(0, 15));
          write_reg(REG_LONG_TIMES, $urandom & 32'h0707_0707);
        end
        4: begin
          write_reg(REG_KEY_ENABLE, 32'h0000_000F);
          write_reg(REG_INVERT, $urandom_range(0, 15));
          write_reg(REG_LONG_TIMES, '0);
        end
        default: begin
          write_reg(REG_INVERT, 32'h0000_000F);
          write_reg(REG_LONG_TIMES, LPT_RST);
        end
      endcase

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender pause: let every outstanding event drain first
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (due_events.size() != 0);
        end
        // time mostly moves forward in realistic steps, sometimes jumps
        r = $urandom_range(0, 99);
        if (r < 4)       clock_ms = $urandom;
        else if (r < 8)  clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else if (r < 10) clock_ms = '0;
        else if (r < 25) clock_ms = clock_ms + $urandom_range(0, 60);
        else if (r < 88) clock_ms = clock_ms + $urandom_range(40, 400);
        else             clock_ms = clock_ms + $urandom_range(400, 3000);
        // usually one key changes, sometimes a random jumble
        r = $urandom_range(0, 99);
        if (r < 55)       level = level ^ (4'b0001 << $urandom_range(0, 3));
        else if (r >= 85) level = 4'($urandom_range(0, 15));
        send_item(clock_ms, level, draw_gap(n), CHK_MODEL, NO_EV);
        n++;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (due_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Event sink: random stalls, two long hold-offs to back the block up
  initial begin : event_sink
    key_event_t want;
    int taken;
    int stall;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken == 40 || taken == 120)  stall = HOLD_OFF_CYCLES;
      else if ((taken / 25) % 3 == 0)   stall = 0;
      else                              stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (due_events.size() == 0) begin
        $error("event with none pending: key_index %0d press_count %0d is_long %0d last_event %0d",
               key_index, press_count, is_long, last_event);
        error_count++;
      end else begin
        want = due_events.pop_front();
        check_field("key_index", want.key, key_index);
        check_field("press_count", want.count, press_count);
        check_field("is_long", want.is_long, is_long);
        check_field("last_event", want.last, last_event);
      end
    end
  end

  // Hang guard
  initial begin : run_limit
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
